// ===== rtl/rgbnv12_pkg.sv =====
`default_nettype none

package rgbnv12_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int SIZE_W      = 14;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LUMA_BASE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LUMA_PITCH   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CHROMA_BASE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CHROMA_PITCH = 3'd5;

  localparam logic [12:0] RST_FRAME_WIDTH  = 13'd1920;
  localparam logic [12:0] RST_FRAME_HEIGHT = 13'd1080;
  localparam logic [31:0] RST_LUMA_BASE    = 32'd0;
  localparam logic [15:0] RST_LUMA_PITCH   = 16'd1920;
  localparam logic [31:0] RST_CHROMA_BASE  = 32'd2073600;
  localparam logic [15:0] RST_CHROMA_PITCH = 16'd1920;

  localparam logic signed [8:0] K_Y_R = 9'sd66;
  localparam logic signed [8:0] K_Y_G = 9'sd129;
  localparam logic signed [8:0] K_Y_B = 9'sd25;
  localparam logic signed [8:0] K_U_R = -9'sd38;
  localparam logic signed [8:0] K_U_G = -9'sd74;
  localparam logic signed [8:0] K_U_B = 9'sd112;
  localparam logic signed [8:0] K_V_R = 9'sd112;
  localparam logic signed [8:0] K_V_G = -9'sd94;
  localparam logic signed [8:0] K_V_B = -9'sd18;
  localparam logic [7:0] LUMA_BIAS = 8'd16;
  localparam logic [7:0] C_OFFSET = 8'd128;
  localparam logic signed [19:0] ROUND_BIAS = 20'sd128;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  luma;
    logic [31:0] luma_address;
    logic        chroma_valid;
    logic [7:0]  cb_value;
    logic [7:0]  cr_value;
    logic [31:0] chroma_address;
    logic        frame_done;
  } result_t;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [31:0] luma_base;
    logic [15:0] luma_pitch;
    logic [31:0] chroma_base;
    logic [15:0] chroma_pitch;
  } cfg_t;

  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
  } pair_sum_t;

  typedef struct packed {
    logic col_wrap;
    logic frame_end;
  } wrap_t;

  function automatic logic [7:0] color_byte(
    input logic [7:0] r,
    input logic [7:0] g,
    input logic [7:0] b,
    input logic signed [8:0] kr,
    input logic signed [8:0] kg,
    input logic signed [8:0] kb,
    input logic [7:0] offset
  );
    logic signed [19:0] acc;
    logic signed [11:0] shifted;
    logic signed [12:0] val;
    logic [7:0] res;
    acc = 20'(kr) * $signed({12'd0, r}) + 20'(kg) * $signed({12'd0, g})
        + 20'(kb) * $signed({12'd0, b}) + ROUND_BIAS;
    shifted = acc[19:8];
    val = {shifted[11], shifted} + $signed({5'd0, offset});
    if (val < 0) begin
      res = 8'd0;
    end else if (val > 13'sd255) begin
      res = 8'd255;
    end else begin
      res = val[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgbnv12_ram.sv =====
`default_nettype none

module rgbnv12_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 2048
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                               rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rgbnv12_cfg.sv =====
`default_nettype none

module rgbnv12_cfg (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  write,
  input  wire logic [rgbnv12_pkg::CFG_INDEX_W-1:0]   index,
  input  wire logic [rgbnv12_pkg::CFG_DATA_W-1:0]    data,
  output rgbnv12_pkg::cfg_t                          cfg
);

  import rgbnv12_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= RST_FRAME_WIDTH;
      cfg.frame_height <= RST_FRAME_HEIGHT;
      cfg.luma_base    <= RST_LUMA_BASE;
      cfg.luma_pitch   <= RST_LUMA_PITCH;
      cfg.chroma_base  <= RST_CHROMA_BASE;
      cfg.chroma_pitch <= RST_CHROMA_PITCH;
    end else if (write) begin
      unique case (index)
        REG_FRAME_WIDTH:  cfg.frame_width  <= data[12:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= data[12:0];
        REG_LUMA_BASE:    cfg.luma_base    <= data[31:0];
        REG_LUMA_PITCH:   cfg.luma_pitch   <= data[15:0];
        REG_CHROMA_BASE:  cfg.chroma_base  <= data[31:0];
        REG_CHROMA_PITCH: cfg.chroma_pitch <= data[15:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rgbnv12_raster.sv =====
`default_nettype none

module rgbnv12_raster #(
  parameter int MAX_WIDTH  = rgbnv12_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgbnv12_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          advance,
  input  wire logic [12:0]                   frame_width,
  input  wire logic [12:0]                   frame_height,
  output logic [$clog2(MAX_WIDTH)-1:0]       column,
  output logic [$clog2(MAX_HEIGHT)-1:0]      row,
  output rgbnv12_pkg::wrap_t                 wrap
);

  import rgbnv12_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [SIZE_W-1:0] width_req;
  logic [SIZE_W-1:0] height_req;
  logic [SIZE_W-1:0] width_eff;
  logic [SIZE_W-1:0] height_eff;

  always_comb begin
    width_req  = SIZE_W'(frame_width);
    height_req = SIZE_W'(frame_height);
    if (width_req < SIZE_W'(2)) begin
      width_eff = SIZE_W'(2);
    end else if (width_req > SIZE_W'(MAX_WIDTH)) begin
      width_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      width_eff = width_req;
    end
    if (height_req < SIZE_W'(2)) begin
      height_eff = SIZE_W'(2);
    end else if (height_req > SIZE_W'(MAX_HEIGHT)) begin
      height_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      height_eff = height_req;
    end
    width_eff[0]  = 1'b0;
    height_eff[0] = 1'b0;
    wrap.col_wrap  = (SIZE_W'(column) + SIZE_W'(1)) >= width_eff;
    wrap.frame_end = wrap.col_wrap && ((SIZE_W'(row) + SIZE_W'(1)) >= height_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (advance) begin
      if (wrap.col_wrap) begin
        column <= '0;
        row    <= wrap.frame_end ? '0 : row + RW'(1);
      end else begin
        column <= column + CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rgb_to_nv12_converter_top.sv =====
// RGB to NV12 converter, BT.601 limited range.
// Pixels enter in raster order on the in channel (valid/ready), one item per
// pixel. Every item produces exactly one result item on the out channel with
// the luma byte and its address; on the odd pixel of an odd row the result
// also carries U, V and the address of the U byte of the 2x2 block.
// An accepted item is held in the s1 registers and then in the output
// register, where out_valid marks it. A new item is accepted every cycle
// while the receiver keeps up, so throughput is one pixel per clock. The
// depth is set by the line buffer's registered read, which is issued as
// the item is accepted, and by the output register. When out_ready is low
// the block holds up to two items (one in flight, one at the output);
// in_ready drops only when both are occupied. Configuration registers are
// written through cfg_write, cfg_index and cfg_data; the user writes them
// only while the block is idle, which the block does not enforce. Reset
// restores the default register values and clears the raster counters and
// the held pixel. The line buffer is not cleared; the first odd row of a
// frame reads entries written by the even row above it.
`default_nettype none

module rgb_to_nv12_converter_top #(
  parameter int MAX_WIDTH  = rgbnv12_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgbnv12_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [rgbnv12_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rgbnv12_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire rgbnv12_pkg::pixel_t                 in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output rgbnv12_pkg::result_t                     out_data
);

  import rgbnv12_pkg::*;

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int RW         = $clog2(MAX_HEIGHT);
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int IW         = $clog2(LINE_DEPTH > 1 ? LINE_DEPTH : 2);

  cfg_t          cfg;
  wrap_t         wrap;
  logic [CW-1:0] column;
  logic [RW-1:0] row;
  logic [CW-1:0] column_even;
  logic          accept;
  logic          s1_advance;

  logic [RW+15:0] luma_row_offset;
  logic [RW+15:0] chroma_row_offset;
  logic [31:0]    luma_address_next;
  logic [31:0]    chroma_address_next;

  logic          s1_valid;
  pixel_t        s1_pixel;
  logic          s1_col_odd;
  logic          s1_row_odd;
  logic [IW-1:0] s1_line_idx;
  logic [31:0]   s1_luma_address;
  logic [31:0]   s1_chroma_address;
  logic          s1_frame_done;

  pixel_t    held_pixel;
  pair_sum_t pair_sum;
  pair_sum_t line_entry;
  logic      line_write;
  logic [9:0] sum_red;
  logic [9:0] sum_green;
  logic [9:0] sum_blue;
  logic [7:0] avg_red;
  logic [7:0] avg_green;
  logic [7:0] avg_blue;
  result_t    result;

  rgbnv12_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .write (cfg_write),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  rgbnv12_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk          (clk),
    .rst          (rst),
    .advance      (accept),
    .frame_width  (cfg.frame_width),
    .frame_height (cfg.frame_height),
    .column       (column),
    .row          (row),
    .wrap         (wrap)
  );

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign accept     = in_valid && in_ready;

  always_comb begin
    column_even         = column & ~CW'(1);
    luma_row_offset     = (RW+16)'(row) * (RW+16)'(cfg.luma_pitch);
    chroma_row_offset   = (RW+16)'(row >> 1) * (RW+16)'(cfg.chroma_pitch);
    luma_address_next   = cfg.luma_base + 32'(luma_row_offset) + 32'(column);
    chroma_address_next = cfg.chroma_base + 32'(chroma_row_offset) + 32'(column_even);
  end

  rgbnv12_ram #(
    .WIDTH ($bits(pair_sum_t)),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (line_write),
    .wr_addr (s1_line_idx),
    .wr_data (pair_sum),
    .rd_en   (accept),
    .rd_addr (IW'(column >> 1)),
    .rd_data (line_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel          <= in_data;
      s1_col_odd        <= column[0];
      s1_row_odd        <= row[0];
      s1_line_idx       <= IW'(column >> 1);
      s1_luma_address   <= luma_address_next;
      s1_chroma_address <= chroma_address_next;
      s1_frame_done     <= wrap.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_pixel <= '0;
    end else if (s1_advance && !s1_col_odd) begin
      held_pixel <= s1_pixel;
    end
  end

  always_comb begin
    pair_sum.red   = 9'(s1_pixel.red) + 9'(held_pixel.red);
    pair_sum.green = 9'(s1_pixel.green) + 9'(held_pixel.green);
    pair_sum.blue  = 9'(s1_pixel.blue) + 9'(held_pixel.blue);
    line_write     = s1_advance && s1_col_odd && !s1_row_odd;
    sum_red        = 10'(pair_sum.red) + 10'(line_entry.red);
    sum_green      = 10'(pair_sum.green) + 10'(line_entry.green);
    sum_blue       = 10'(pair_sum.blue) + 10'(line_entry.blue);
    avg_red        = sum_red[9:2];
    avg_green      = sum_green[9:2];
    avg_blue       = sum_blue[9:2];

    result.luma         = color_byte(s1_pixel.red, s1_pixel.green, s1_pixel.blue,
                                     K_Y_R, K_Y_G, K_Y_B, LUMA_BIAS);
    result.luma_address = s1_luma_address;
    result.chroma_valid = s1_col_odd && s1_row_odd;
    result.frame_done   = s1_frame_done;
    if (result.chroma_valid) begin
      result.cb_value       = color_byte(avg_red, avg_green, avg_blue,
                                         K_U_R, K_U_G, K_U_B, C_OFFSET);
      result.cr_value       = color_byte(avg_red, avg_green, avg_blue,
                                         K_V_R, K_V_G, K_V_B, C_OFFSET);
      result.chroma_address = s1_chroma_address;
    end else begin
      result.cb_value       = 8'd0;
      result.cr_value       = 8'd0;
      result.chroma_address = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire
